@@ rtl/trial_division_prime_tester_defines.svh @@
// Assertion macros shared by the files that carry checks.
// Define NO_ASSERTIONS to compile every check away.
`ifndef TRIAL_DIVISION_PRIME_TESTER_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TESTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define TDPT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdpt check failed: same-cycle rule");

// The consequent must hold in the cycle after the antecedent.
`define TDPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdpt check failed: next-cycle rule");

`else

`define TDPT_ASSERT_SAME(label, clk, rst, ante, cons)
`define TDPT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/tdpt_pkg.sv @@
package tdpt_pkg;

   // Width of a candidate and of the echoed value.
   localparam int unsigned VALUE_BITS = 32;

   // Defaults for the base prime table.
   localparam int unsigned TABLE_DEPTH_DEFAULT = 8192;
   localparam int unsigned PRIME_BITS_DEFAULT  = 16;

   // Register port geometry.
   localparam int unsigned CSR_ADDR_BITS  = 3;
   localparam int unsigned CSR_DATA_BITS  = 32;
   localparam int unsigned CSR_INDEX_BITS = CSR_ADDR_BITS - 2;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_UPPER_LIMIT = '0;

   // Reset value of the upper limit register.
   localparam logic [CSR_DATA_BITS-1:0] UPPER_LIMIT_RESET = '1;

   // Verdict codes.
   typedef enum logic [1:0] {
      VERDICT_COMPOSITE = 2'd0,
      VERDICT_PRIME     = 2'd1,
      VERDICT_UNDECIDED = 2'd2
   } verdict_type;

   // Status reported by the remainder unit.
   typedef struct packed {
      logic done;
      logic zero;
   } rem_status_type;

endpackage

@@ rtl/tdpt_ram.sv @@
module tdpt_ram
   import tdpt_pkg::*;
#(
   parameter int unsigned WIDTH = PRIME_BITS_DEFAULT,
   parameter int unsigned DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tdpt_rem_unit.sv @@
module tdpt_rem_unit
   import tdpt_pkg::*;
#(
   parameter int unsigned PRIME_BITS = PRIME_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [PRIME_BITS-1:0] divisor,
   output rem_status_type        status
);

   localparam int unsigned STEP_W = $clog2(VALUE_BITS);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [VALUE_BITS-1:0] dvd_ff, dvd_in;
   logic [PRIME_BITS-1:0] div_ff, div_in;
   logic [PRIME_BITS-1:0] rem_ff, rem_in;
   logic [PRIME_BITS:0]   trial;
   logic [PRIME_BITS:0]   diff;

   // Restoring division: one dividend bit is brought down each cycle.
   always_comb begin
      trial   = {rem_ff, dvd_ff[VALUE_BITS-1]};
      diff    = trial - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(VALUE_BITS - 1);
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[VALUE_BITS-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[PRIME_BITS-1:0];
         end else begin
            rem_in = trial[PRIME_BITS-1:0];
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
   end

   assign status = {done_ff, (rem_ff == '0)};

endmodule

@@ rtl/trial_division_prime_tester.sv @@
// Trial-division prime tester. Each request carries a candidate, and each gives
// exactly one response with the candidate echoed and a verdict: composite, prime,
// or undecided when the stored base primes run out before their square passes the
// candidate. Candidates should arrive in ascending order from 2, so that primes
// whose square does not exceed upper_limit build up the base table in order. One
// candidate is worked at a time and req_stall is high meanwhile. Each base prime
// that a candidate is divided by passes through the bit-serial remainder unit.
// Candidates below 2 skip the table and are answered composite. The response
// sits in an output register, so a new request is taken while it waits.
`include "trial_division_prime_tester_defines.svh"

module trial_division_prime_tester
   import tdpt_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
   parameter int unsigned PRIME_BITS  = PRIME_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   // Request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [VALUE_BITS-1:0]    req_candidate,
   // Response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [VALUE_BITS-1:0]    rsp_tested_value,
   output logic [1:0]               rsp_verdict,
   // Register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned NEXT_W = VALUE_BITS + 1;
   localparam int unsigned SQ_W   = 2 * VALUE_BITS;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_READ   = 8'b0000_0010,
      S_PSQ    = 8'b0000_0100,
      S_DIV    = 8'b0000_1000,
      S_NEXT   = 8'b0001_0000,
      S_NSQ    = 8'b0010_0000,
      S_CSQ    = 8'b0100_0000,
      S_FINISH = 8'b1000_0000
   } state_type;

   state_type             state_ff, state_in;
   verdict_type           verdict_ff, verdict_in;
   logic [VALUE_BITS-1:0] cand_ff, cand_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic [PRIME_BITS-1:0] p_ff, p_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [PRIME_BITS-1:0] last_ff, last_in;
   logic [SQ_W-1:0]       sq_ff;
   logic [CSR_DATA_BITS-1:0] limit_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   verdict_type           rsp_verdict_ff;

   logic                  sq_load;
   logic [VALUE_BITS-1:0] sq_a;
   logic                  rem_start;
   rem_status_type        rem_status;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [PRIME_BITS-1:0] rd_data;
   logic                  wr_en;
   logic                  load_out;
   logic                  out_free;
   logic [CNT_W-1:0]      next_idx;
   logic [NEXT_W-1:0]     next_wide;
   logic                  append_ok;
   logic                  csr_write;
   logic                  cand_gt_square;

   // Base prime table.
   tdpt_ram #(
      .WIDTH (PRIME_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (cand_ff[PRIME_BITS-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared bit-serial remainder unit.
   tdpt_rem_unit #(
      .PRIME_BITS (PRIME_BITS)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (cand_ff),
      .divisor  (p_ff),
      .status   (rem_status)
   );

   // Register port: writes complete in the access phase, reads are immediate.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[CSR_ADDR_BITS-1:2] == REG_UPPER_LIMIT) ? limit_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= UPPER_LIMIT_RESET;
      end else if (csr_write && (csr_paddr[CSR_ADDR_BITS-1:2] == REG_UPPER_LIMIT)) begin
         limit_ff <= csr_pwdata;
      end
   end

   // Shared squaring unit, registered so that the compare sits in the next cycle.
   always_ff @(posedge clock) begin
      if (sq_load) begin
         sq_ff <= SQ_W'(sq_a) * SQ_W'(sq_a);
      end
   end

   // Helper values for the sequencer.
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign next_idx       = CNT_W'(idx_ff) + CNT_W'(1);
   assign next_wide      = (count_ff == '0) ? NEXT_W'(2) : NEXT_W'(last_ff) + NEXT_W'(1);
   assign cand_gt_square = sq_ff > SQ_W'(cand_ff);
   assign append_ok      = (count_ff < CNT_W'(TABLE_DEPTH))
                           && ((cand_ff >> PRIME_BITS) == '0)
                           && (sq_ff <= SQ_W'(limit_ff))
                           && ((count_ff == '0) || (cand_ff > VALUE_BITS'(last_ff)));

   // Sequencer: walk the table one base prime at a time.
   always_comb begin
      state_in   = state_ff;
      verdict_in = verdict_ff;
      cand_in    = cand_ff;
      idx_in     = idx_ff;
      p_in       = p_ff;
      count_in   = count_ff;
      last_in    = last_ff;
      sq_load    = 1'b0;
      sq_a       = cand_ff;
      rem_start  = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = idx_ff;
      wr_en      = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cand_in = req_candidate;
               idx_in  = '0;
               if (req_candidate < VALUE_BITS'(2)) begin
                  verdict_in = VERDICT_COMPOSITE;
                  state_in   = S_FINISH;
               end else if (count_ff == '0) begin
                  state_in = S_NEXT;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            p_in = rd_data;
            if (rd_data == '0) begin
               verdict_in = VERDICT_UNDECIDED;
               state_in   = S_FINISH;
            end else begin
               sq_a     = VALUE_BITS'(rd_data);
               sq_load  = 1'b1;
               state_in = S_PSQ;
            end
         end
         S_PSQ: begin
            if (cand_gt_square) begin
               verdict_in = VERDICT_PRIME;
               state_in   = S_CSQ;
            end else begin
               rem_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_status.done) begin
               if (rem_status.zero) begin
                  verdict_in = VERDICT_COMPOSITE;
                  state_in   = S_FINISH;
               end else if (next_idx == count_ff) begin
                  state_in = S_NEXT;
               end else begin
                  idx_in   = next_idx[ADDR_W-1:0];
                  rd_en    = 1'b1;
                  rd_addr  = next_idx[ADDR_W-1:0];
                  state_in = S_READ;
               end
            end
         end
         S_NEXT: begin
            // The smallest prime missing from the table is at least next_wide.
            if (next_wide[VALUE_BITS]) begin
               verdict_in = VERDICT_PRIME;
               state_in   = S_CSQ;
            end else begin
               sq_a     = next_wide[VALUE_BITS-1:0];
               sq_load  = 1'b1;
               state_in = S_NSQ;
            end
         end
         S_NSQ: begin
            if (cand_gt_square) begin
               verdict_in = VERDICT_PRIME;
               state_in   = S_CSQ;
            end else begin
               verdict_in = VERDICT_UNDECIDED;
               state_in   = S_FINISH;
            end
         end
         S_CSQ: begin
            // Square the candidate for the append check against the limit.
            sq_a     = cand_ff;
            sq_load  = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               load_out = 1'b1;
               if ((verdict_ff == VERDICT_PRIME) && append_ok) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  last_in  = cand_ff[PRIME_BITS-1:0];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      verdict_ff <= verdict_in;
      cand_ff    <= cand_in;
      idx_ff     <= idx_in;
      p_ff       <= p_in;
      last_ff    <= last_in;
      if (load_out) begin
         rsp_value_ff   <= cand_ff;
         rsp_verdict_ff <= verdict_ff;
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tested_value = rsp_value_ff;
   assign rsp_verdict      = rsp_verdict_ff;

   // A table write only ever follows a prime verdict on a table that has room.
   `TDPT_ASSERT_SAME(a_append_prime_only, clock, reset, wr_en,
      (verdict_ff == VERDICT_PRIME) && (count_ff < CNT_W'(TABLE_DEPTH)) && (state_ff == S_FINISH))

   // The remainder unit reports back only while the sequencer waits for it.
   `TDPT_ASSERT_SAME(a_rem_done_in_div, clock, reset, rem_status.done, state_ff == S_DIV)

   // Each table write grows the count by exactly one.
   `TDPT_ASSERT_NEXT(a_count_steps, clock, reset, wr_en, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

@@ dv/trial_division_prime_tester_tb.sv @@
`timescale 1ns / 1ps

module trial_division_prime_tester_tb;
   import tdpt_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 10_000_000;
   localparam int unsigned TAIL_CYCLES = 100;
   localparam longint unsigned PRIME_MAX = (64'd1 << PRIME_BITS_DEFAULT) - 1;
   localparam logic [CSR_ADDR_BITS-1:0] LIMIT_ADDR = {REG_UPPER_LIMIT, 2'b00};

   // Mirror of the base prime table and the verdicts still owed by the block.
   class primality_scoreboard;
      logic [PRIME_BITS_DEFAULT-1:0] base_primes [TABLE_DEPTH_DEFAULT];
      int unsigned                   prime_count;
      logic [CSR_DATA_BITS-1:0]      upper_limit;
      logic [VALUE_BITS-1:0]         owed_values [$];
      verdict_type                   owed_verdicts [$];
      int unsigned                   mismatches;

      function new();
         prime_count = 0;
         upper_limit = UPPER_LIMIT_RESET;
         mismatches  = 0;
      endfunction

      function void set_limit(logic [CSR_DATA_BITS-1:0] value);
         upper_limit = value;
      endfunction

      function int unsigned pending();
         return owed_values.size();
      endfunction

      function void mismatch(string msg);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%s", msg);
         end
      endfunction

      // A base prime above 32 bits always has a square beyond any candidate.
      function bit square_above(longint unsigned q, longint unsigned c);
         if (q > 64'hFFFF_FFFF) begin
            return 1'b1;
         end
         return (q * q) > c;
      endfunction

      // Walks the table in order until a divisor turns up or p*p passes c.
      function verdict_type trial_verdict(longint unsigned c);
         int unsigned     i;
         longint unsigned p;
         longint unsigned bound;
         if (c < 2) begin
            return VERDICT_COMPOSITE;
         end
         for (i = 0; i < prime_count; i++) begin
            p = base_primes[i];
            if (p == 0) begin
               return VERDICT_UNDECIDED;
            end
            if (square_above(p, c)) begin
               return VERDICT_PRIME;
            end
            if ((c % p) == 0) begin
               return VERDICT_COMPOSITE;
            end
         end
         // Table exhausted: the next prime is at least one past the last entry.
         if (prime_count == 0) begin
            bound = 2;
         end else begin
            bound = longint'(base_primes[prime_count - 1]) + 1;
         end
         return square_above(bound, c) ? VERDICT_PRIME : VERDICT_UNDECIDED;
      endfunction

      // A prime joins the table only if it fits, is in range and ascends.
      function void extend_table(longint unsigned c);
         longint unsigned lim;
         lim = upper_limit;
         if (prime_count >= TABLE_DEPTH_DEFAULT) begin
            return;
         end
         if (c > PRIME_MAX || c < 2) begin
            return;
         end
         if (c > lim / c) begin
            return;
         end
         if (prime_count > 0 && c <= base_primes[prime_count - 1]) begin
            return;
         end
         base_primes[prime_count] = c[PRIME_BITS_DEFAULT-1:0];
         prime_count++;
      endfunction

      function void note_candidate(logic [VALUE_BITS-1:0] candidate);
         verdict_type v;
         v = trial_verdict(candidate);
         if (v == VERDICT_PRIME) begin
            extend_table(candidate);
         end
         owed_values   = {owed_values, candidate};
         owed_verdicts = {owed_verdicts, v};
      endfunction

      function void check_response(logic [VALUE_BITS-1:0] value, logic [1:0] verdict);
         logic [VALUE_BITS-1:0] exp_value;
         verdict_type           exp_verdict;
         if (owed_values.size() == 0) begin
            mismatch($sformatf("unexpected response: value %0d verdict %0d", value, verdict));
            return;
         end
         exp_value   = owed_values.pop_front();
         exp_verdict = owed_verdicts.pop_front();
         if (value !== exp_value) begin
            mismatch($sformatf("tested_value mismatch: expected %0d, got %0d",
                               exp_value, value));
         end
         if (verdict !== exp_verdict) begin
            mismatch($sformatf("verdict mismatch for %0d: expected %0d, got %0d",
                               exp_value, exp_verdict, verdict));
         end
      endfunction
   endclass

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   logic [VALUE_BITS-1:0]    req_candidate = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   logic [VALUE_BITS-1:0]    rsp_tested_value;
   logic [1:0]               rsp_verdict;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   bit                       steady = 1'b0;
   int unsigned              cycle_count = 0;
   primality_scoreboard      sb;

   trial_division_prime_tester u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_candidate    (req_candidate),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tested_value (rsp_tested_value),
      .rsp_verdict      (rsp_verdict),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #4 clock = ~clock;

   // Response side: check each accepted response and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_tested_value, rsp_verdict);
      end
      rsp_stall <= !steady && ($urandom_range(99) < 27);
   end

   // Watchdog against a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("trial_division_prime_tester_tb NOT OK");
         $finish;
      end
   end

   // Offers one request after a random gap and waits for it to be taken.
   task automatic send_candidate(input logic [VALUE_BITS-1:0] candidate);
      int unsigned gap;
      gap = 0;
      while (!steady && $urandom_range(99) < 27) begin
         gap++;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_candidate <= candidate;
      do @(posedge clock); while (req_stall);
      sb.note_candidate(candidate);
   endtask

   // Stray values: anywhere in the range, below 2, out of order, near the top.
   function automatic logic [VALUE_BITS-1:0] stray_value(logic [VALUE_BITS-1:0] ceiling);
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(1);
         2: return $urandom_range(ceiling);
         default: return ~VALUE_BITS'($urandom_range(255));
      endcase
   endfunction

   // Counts up from 2, mostly in steps of one, sometimes stepping over an even
   // number, with stray values mixed in. Idling stops in the steady window.
   task automatic run_ascending(input int unsigned top, input int unsigned steady_from);
      logic [VALUE_BITS-1:0] c;
      c = 2;
      while (c <= top) begin
         steady = (steady_from != 0) && (c >= steady_from) && (c < steady_from + 80);
         if ($urandom_range(99) < 12) begin
            send_candidate(stray_value(c));
         end else begin
            send_candidate(c);
            if (c > 2 && c[0] && $urandom_range(99) < 30) begin
               c += 2;
            end else begin
               c += 1;
            end
         end
      end
      steady = 1'b0;
   endtask

   // Lowers valid and waits for every owed response.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // One register transfer; a read is checked against the mirrored limit.
   // The caller closes the transfer by lowering psel and penable.
   task automatic csr_transfer(input bit is_write, input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= LIMIT_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (is_write) begin
         sb.set_limit(value);
      end else if (csr_prdata !== sb.upper_limit) begin
         sb.mismatch($sformatf("upper_limit read: expected %0d, got %0d",
                               sb.upper_limit, csr_prdata));
      end
   endtask

   task automatic program_limit(input logic [CSR_DATA_BITS-1:0] value);
      csr_transfer(1'b1, value);
      csr_transfer(1'b0, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The register comes out of reset at its full value.
      csr_transfer(1'b0, '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);

      // Lowest limit: nothing ever enters the table, so only 2 and 3 are prime.
      program_limit(32'd2);
      send_candidate(32'd0);
      send_candidate(32'd1);
      send_candidate(32'd2);
      send_candidate(32'd3);
      send_candidate(32'd4);
      send_candidate(32'd5);
      send_candidate(32'hFFFF_FFFF);
      send_candidate(32'h8000_0000);
      repeat (30) send_candidate(stray_value(32'd1000));
      drain();

      // Limit 100 keeps the table at 2, 3, 5 and 7. A repeated 3 is out of
      // order, 53 runs off the end of the table yet is still prime, and a large
      // prime is left undecided.
      program_limit(32'd100);
      send_candidate(32'd2);
      send_candidate(32'd3);
      send_candidate(32'd4);
      send_candidate(32'd5);
      send_candidate(32'd7);
      send_candidate(32'd3);
      send_candidate(32'd53);
      send_candidate(32'd64);
      send_candidate(32'hFFFF_FFFB);
      run_ascending(120, 0);
      drain();

      // A random limit in the middle of the range.
      program_limit($urandom_range(200, 70000));
      run_ascending(150, 0);
      drain();

      // Full limit: the table grows past 257, with a stretch of no idling.
      program_limit(32'hFFFF_FFFF);
      run_ascending(350, 120);
      // 65537 is prime but too wide for the table; 65521 is the widest that fits.
      send_candidate(32'd65537);
      send_candidate(32'd65521);
      send_candidate(32'hFFFF_FFFB);
      send_candidate(32'hFFFF_FFFF);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("trial_division_prime_tester_tb OK");
      end else begin
         $display("trial_division_prime_tester_tb NOT OK");
      end
      $finish;
   end

endmodule
